### hw/rtl/ctc_pkg.sv
`timescale 1ns / 1ps
package ctc_pkg;

	localparam int ENC_W              = 14;
	localparam int TIME_W             = 13;
	localparam int DEFAULT_ENC_WRAP   = 9999;

	localparam logic [1:0] STEP_UP    = 2'b01;
	localparam logic [1:0] STEP_DOWN  = 2'b11;

	localparam logic [TIME_W-1:0] SEC_MAX     = 13'd59;
	localparam logic [TIME_W-1:0] MIN_MAX     = 13'd99;
	localparam logic [TIME_W-1:0] PRESET_LIM  = 13'd5999;
	localparam logic [TIME_W-1:0] ELAPSED_SAT = 13'd8191;

	// floor(t / 60) == (t * DIV60_MUL) >> DIV60_SH for every 13-bit t
	localparam int DIV60_MUL = 8739;
	localparam int DIV60_SH  = 19;
	// floor(v / 10) == (v * DIV10_MUL) >> DIV10_SH for v below 1029
	localparam int DIV10_MUL = 205;
	localparam int DIV10_SH  = 11;

	typedef enum logic [2:0] {
		MODE_SHOW     = 3'd0,
		MODE_SET_SEC  = 3'd1,
		MODE_SET_MIN  = 3'd2,
		MODE_ARM      = 3'd3,
		MODE_COUNT    = 3'd4,
		MODE_ALARM_ON = 3'd5,
		MODE_ALARM    = 3'd6,
		MODE_RESET    = 3'd7
	} mode_t;

	typedef struct packed {
		logic [TIME_W-1:0] shown_time;
		logic [1:0]        flash;
		logic              buzzer;
		mode_t             mode;
	} view_t;

endpackage

### hw/rtl/ctc_ctrl.sv
`timescale 1ns / 1ps
module ctc_ctrl
	import ctc_pkg::*;
#(
	parameter int ENCODER_WRAP = DEFAULT_ENC_WRAP
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic signed [1:0] encoder_step,
	input  logic              start_reset_press,
	input  logic              time_set_press,
	input  logic              second_tick,
	output view_t             view
);

	localparam logic [ENC_W-1:0] WRAP = ENC_W'(ENCODER_WRAP);

	mode_t             mode_q, mode_d;
	logic [ENC_W-1:0]  pos_q, pos_d;
	logic [5:0]        set_sec_q, set_sec_d;
	logic [6:0]        set_min_q, set_min_d;
	logic [TIME_W-1:0] preset_q, preset_d;
	logic [TIME_W-1:0] elapsed_q, elapsed_d;
	logic              running_q, running_d;
	logic              buzzer_q, buzzer_d;
	logic              pstart_q, pstart_d;
	logic              pset_q, pset_d;
	logic [1:0]        flash_q, flash_d;
	logic [TIME_W-1:0] shown_q, shown_d;

	logic [1:0]        step_bits;
	logic [ENC_W-1:0]  pos_step;
	logic [TIME_W-1:0] half;
	logic [TIME_W-1:0] total;

	assign step_bits = encoder_step;

	always_comb begin
		mode_d    = mode_q;
		set_sec_d = set_sec_q;
		set_min_d = set_min_q;
		preset_d  = preset_q;
		running_d = running_q;
		buzzer_d  = buzzer_q;
		flash_d   = flash_q;
		shown_d   = shown_q;

		pos_step = pos_q;
		if (step_bits == STEP_UP) begin
			pos_step = (pos_q >= WRAP) ? '0 : pos_q + 1'b1;
		end else if (step_bits == STEP_DOWN) begin
			pos_step = (pos_q == '0 || pos_q > WRAP) ? WRAP : pos_q - 1'b1;
		end
		pos_d = pos_step;

		pstart_d  = pstart_q | start_reset_press;
		pset_d    = pset_q | time_set_press;
		elapsed_d = elapsed_q;
		if (second_tick && running_q && elapsed_q < ELAPSED_SAT) begin
			elapsed_d = elapsed_q + 1'b1;
		end

		half  = pos_step[ENC_W-1:1];
		total = '0;

		unique case (mode_q)
			MODE_SHOW: begin
				shown_d = preset_q;
				if (pset_d) begin
					pset_d  = 1'b0;
					pos_d   = '0;
					flash_d = 2'b01;
					mode_d  = MODE_SET_SEC;
				end
			end
			MODE_SET_SEC, MODE_SET_MIN: begin
				// out-of-range half position snaps the encoder back to zero
				if (mode_q == MODE_SET_SEC) begin
					if (half > SEC_MAX) begin
						pos_d     = '0;
						set_sec_d = '0;
					end else begin
						set_sec_d = half[5:0];
					end
				end else begin
					if (half > MIN_MAX) begin
						pos_d     = '0;
						set_min_d = '0;
					end else begin
						set_min_d = half[6:0];
					end
				end
				total   = TIME_W'(set_min_d) * TIME_W'(60) + TIME_W'(set_sec_d);
				shown_d = total;
				if (pstart_d) begin
					pstart_d = 1'b0;
					pos_d    = '0;
					preset_d = total;
					mode_d   = MODE_ARM;
				end else if (pset_d) begin
					pset_d = 1'b0;
					if (mode_q == MODE_SET_SEC) begin
						pos_d   = {ENC_W'(set_min_d)} << 1;
						flash_d = 2'b10;
						mode_d  = MODE_SET_MIN;
					end else begin
						pos_d   = {ENC_W'(set_sec_d)} << 1;
						flash_d = 2'b01;
						mode_d  = MODE_SET_SEC;
					end
				end
			end
			MODE_ARM: begin
				flash_d = 2'b00;
				if (preset_q != '0 && preset_q < PRESET_LIM) begin
					running_d = 1'b1;
					elapsed_d = '0;
					mode_d    = MODE_COUNT;
				end else begin
					mode_d = MODE_RESET;
				end
			end
			MODE_COUNT: begin
				shown_d = (elapsed_d > preset_q) ? '0 : preset_q - elapsed_d;
				if (elapsed_d >= preset_q) begin
					mode_d = MODE_ALARM_ON;
				end else if (pstart_d) begin
					pstart_d = 1'b0;
					mode_d   = MODE_RESET;
				end
			end
			MODE_ALARM_ON: begin
				running_d = 1'b0;
				elapsed_d = '0;
				buzzer_d  = 1'b1;
				mode_d    = MODE_ALARM;
			end
			MODE_ALARM: begin
				if (pstart_d) begin
					pstart_d = 1'b0;
					mode_d   = MODE_RESET;
				end
			end
			MODE_RESET: begin
				buzzer_d = 1'b0;
				preset_d = '0;
				pos_d    = '0;
				flash_d  = 2'b00;
				mode_d   = MODE_SHOW;
			end
		endcase

		view.shown_time = shown_d;
		view.flash      = flash_d;
		view.buzzer     = buzzer_d;
		view.mode       = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RESET;
			pos_q     <= '0;
			set_sec_q <= '0;
			set_min_q <= '0;
			preset_q  <= '0;
			elapsed_q <= '0;
			running_q <= 1'b0;
			buzzer_q  <= 1'b0;
			pstart_q  <= 1'b0;
			pset_q    <= 1'b0;
			flash_q   <= '0;
			shown_q   <= '0;
		end else if (accept) begin
			mode_q    <= mode_d;
			pos_q     <= pos_d;
			set_sec_q <= set_sec_d;
			set_min_q <= set_min_d;
			preset_q  <= preset_d;
			elapsed_q <= elapsed_d;
			running_q <= running_d;
			buzzer_q  <= buzzer_d;
			pstart_q  <= pstart_d;
			pset_q    <= pset_d;
			flash_q   <= flash_d;
			shown_q   <= shown_d;
		end
	end

endmodule

### hw/rtl/countdown_timer_controller_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// in       to block   in_valid/in_stall  encoder_step, start_reset_press, time_set_press,
//                                        second_tick
// out      from block out_valid/out_stall digit_sec_ones, digit_sec_tens, digit_min_ones,
//                                        digit_min_tens, seconds_flashing, minutes_flashing,
//                                        buzzer_on, mode_code
//
// One word in per cycle while in_stall is low; its result passes the view, minutes/seconds and digit registers.
// The controller state advances on the accept edge; display time then goes
// through a divide-by-60 stage and a decimal digit stage.
// Reset (arst_n low) puts the controller in its reset mode and empties the pipeline.
// Output stalls back up through the three stages; the input stalls only when all are full.
module countdown_timer_controller_core
	import ctc_pkg::*;
#(
	parameter int ENCODER_WRAP = DEFAULT_ENC_WRAP
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [1:0] encoder_step,
	input  logic              start_reset_press,
	input  logic              time_set_press,
	input  logic              second_tick,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        digit_sec_ones,
	output logic [3:0]        digit_sec_tens,
	output logic [3:0]        digit_min_ones,
	output logic [3:0]        digit_min_tens,
	output logic              seconds_flashing,
	output logic              minutes_flashing,
	output logic              buzzer_on,
	output logic [2:0]        mode_code
);

	localparam int PROD_W = 27;

	logic  accept;
	view_t view;

	logic  v_s1, v_s2, v_s3;
	logic  rdy_s1, rdy_s2, rdy_s3;

	view_t view_s1;

	logic [7:0]  min_s2;
	logic [5:0]  sec_s2;
	logic [1:0]  flash_s2;
	logic        buzzer_s2;
	mode_t       mode_s2;

	logic [PROD_W-1:0] quot_prod;
	logic [7:0]        quot;
	logic [TIME_W-1:0] rem_full;

	logic [14:0] sec_prod;
	logic [15:0] min_prod;
	logic [3:0]  sec_tens;
	logic [4:0]  min_tens_raw;
	logic [3:0]  sec_ones;
	logic [3:0]  min_ones;
	logic [3:0]  min_tens;

	// a stage takes a new word when it is empty or its word moves on
	assign rdy_s3   = !v_s3 || !out_stall;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign accept   = in_valid && rdy_s1;

	ctc_ctrl #(
		.ENCODER_WRAP(ENCODER_WRAP)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.encoder_step     (encoder_step),
		.start_reset_press(start_reset_press),
		.time_set_press   (time_set_press),
		.second_tick      (second_tick),
		.view             (view)
	);

	always_comb begin
		quot_prod = PROD_W'(view_s1.shown_time) * PROD_W'(DIV60_MUL);
		quot      = quot_prod[DIV60_SH+7:DIV60_SH];
		rem_full  = view_s1.shown_time - TIME_W'(quot) * TIME_W'(60);
	end

	always_comb begin
		sec_prod     = 15'(sec_s2) * 15'(DIV10_MUL);
		sec_tens     = sec_prod[DIV10_SH+3:DIV10_SH];
		sec_ones     = 4'(sec_s2 - 6'(sec_tens) * 6'd10);
		min_prod     = 16'(min_s2) * 16'(DIV10_MUL);
		min_tens_raw = min_prod[DIV10_SH+4:DIV10_SH];
		min_ones     = 4'(min_s2 - 8'(min_tens_raw) * 8'd10);
		// minutes reach 99 at most (136 over the full 13-bit range), so the hundreds fold with one subtract
		min_tens     = (min_tens_raw >= 5'd10) ? 4'(min_tens_raw - 5'd10) : min_tens_raw[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			view_s1 <= view;
		end
		if (rdy_s2 && v_s1) begin
			min_s2    <= quot;
			sec_s2    <= rem_full[5:0];
			flash_s2  <= view_s1.flash;
			buzzer_s2 <= view_s1.buzzer;
			mode_s2   <= view_s1.mode;
		end
		if (rdy_s3 && v_s2) begin
			digit_sec_ones   <= sec_ones;
			digit_sec_tens   <= sec_tens;
			digit_min_ones   <= min_ones;
			digit_min_tens   <= min_tens;
			seconds_flashing <= flash_s2[0];
			minutes_flashing <= flash_s2[1];
			buzzer_on        <= buzzer_s2;
			mode_code        <= mode_s2;
		end
	end

	assign out_valid = v_s3;

endmodule
